>>> src/ipu_pkg.sv
// shared types and constants for the interval peak usage block
`timescale 1ns / 1ps
`default_nettype none

package ipu_pkg;

	localparam int CELLS       = 4;
	localparam int LANE_W      = 2;
	localparam int STEP_W      = 12;
	localparam int FULL_STEP_W = 16;
	localparam int SIZE_W      = 48;
	localparam int USAGE_W     = 56;
	localparam int COUNT_W     = 13;

	localparam logic [USAGE_W-1:0] USAGE_MAX = {USAGE_W{1'b1}};

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ADD,
		OP_SEARCH,
		OP_CLEAR,
		OP_START,
		OP_REDUCE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [SIZE_W-1:0] size;
	} cell_cmd_t;

	typedef struct packed {
		logic [USAGE_W-1:0]     usage;
		logic [FULL_STEP_W-1:0] step;
	} best_t;

	typedef struct packed {
		logic [STEP_W-1:0] start_step;
		logic [STEP_W-1:0] end_step;
		logic [SIZE_W-1:0] size_bytes;
		logic              last_interval;
	} item_t;

	typedef struct packed {
		logic [USAGE_W-1:0] peak_bytes;
		logic [STEP_W-1:0]  peak_step;
	} result_t;

endpackage

`default_nettype wire

>>> src/ipu_cell.sv
// one cell of the usage row: a bank of step usage, a local peak and a chain stage
`timescale 1ns / 1ps
`default_nettype none

module ipu_cell #(
	parameter int ROWS = 1024,
	parameter int LANE = 0,
	localparam int ROW_W = $clog2(ROWS)
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire ipu_pkg::cell_cmd_t   cmd,
	input  wire [ROW_W-1:0]           row,
	input  wire                       en,
	input  wire ipu_pkg::best_t       chain_in,
	output ipu_pkg::best_t            chain_out
);

	logic [ipu_pkg::USAGE_W-1:0] mem [ROWS];
	logic [ipu_pkg::USAGE_W-1:0] rdata_q;

	ipu_pkg::cell_op_t         op_s1;
	logic [ROW_W-1:0]          row_s1;
	logic                      en_s1;
	logic [ipu_pkg::SIZE_W-1:0] size_s1;

	ipu_pkg::best_t best_q;
	ipu_pkg::best_t chain_q;

	logic [ipu_pkg::USAGE_W:0]      sum;
	logic [ipu_pkg::USAGE_W-1:0]    sat_sum;
	logic [ipu_pkg::FULL_STEP_W-1:0] lane_step;
	logic                           wr_en;
	logic [ROW_W-1:0]               wr_row;
	logic [ipu_pkg::USAGE_W-1:0]    wr_data;
	ipu_pkg::best_t                 better;

	assign sum     = {1'b0, rdata_q} + (ipu_pkg::USAGE_W + 1)'(size_s1);
	assign sat_sum = sum[ipu_pkg::USAGE_W] ? ipu_pkg::USAGE_MAX : sum[ipu_pkg::USAGE_W-1:0];

	assign lane_step = (ipu_pkg::FULL_STEP_W'(row_s1) << ipu_pkg::LANE_W)
		| ipu_pkg::FULL_STEP_W'(LANE);

	// single write port: the write-back of an add or search wins over a row clear
	always_comb begin
		wr_en   = 1'b0;
		wr_row  = row_s1;
		wr_data = '0;
		case (op_s1)
			ipu_pkg::OP_ADD: begin
				wr_en   = en_s1;
				wr_data = sat_sum;
			end
			ipu_pkg::OP_SEARCH: begin
				wr_en = 1'b1;
			end
			default: begin
				if (cmd.op == ipu_pkg::OP_CLEAR) begin
					wr_en  = 1'b1;
					wr_row = row;
				end
			end
		endcase
	end

	// neighbor's candidate wins on larger usage, or equal usage at a lower step
	always_comb begin
		better = best_q;
		if (chain_in.usage > best_q.usage) begin
			better = chain_in;
		end else if (chain_in.usage == best_q.usage && chain_in.step < best_q.step) begin
			better = chain_in;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (cmd.op == ipu_pkg::OP_ADD || cmd.op == ipu_pkg::OP_SEARCH) begin
			rdata_q <= mem[row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1   <= ipu_pkg::OP_NONE;
			row_s1  <= '0;
			en_s1   <= 1'b0;
			size_s1 <= '0;
			best_q  <= '0;
			chain_q <= '0;
		end else begin
			op_s1   <= cmd.op;
			row_s1  <= row;
			en_s1   <= en;
			size_s1 <= cmd.size;
			if (cmd.op == ipu_pkg::OP_START) begin
				best_q <= '0;
			end else if (op_s1 == ipu_pkg::OP_SEARCH && en_s1 && rdata_q > best_q.usage) begin
				best_q.usage <= rdata_q;
				best_q.step  <= lane_step;
			end
			if (cmd.op == ipu_pkg::OP_REDUCE) begin
				chain_q <= better;
			end
		end
	end

	assign chain_out = chain_q;

endmodule

`default_nettype wire

>>> src/interval_peak_usage_core.sv
// top level: interval walk controller, row of usage cells and result register
`timescale 1ns / 1ps
`default_nettype none

// Peak per-step usage over a run of lifetime intervals. Step usage lives in
// four cells, each owning every fourth step in a bank of MAX_STEPS/4 rows
// (rounded up), so an interval is walked one row (four steps) per cycle over
// the rows that its span, clipped to the step count, touches, and the block
// returns to idle before it takes the next item; an empty or out-of-range
// interval is taken while idle, with no walk. The item marked last adds
// a search: a drain state arms the cells, one pass over every row reads
// each usage and clears it, a settle state follows, the reduce state lets
// the peak ripple through the cell chain, and the output state loads the
// result register, which waits as long as the receiver still stalls an
// earlier result. After reset the block clears every row of the banks before
// it takes an item; step_count writes are taken at any time.
module interval_peak_usage_core #(
	parameter int MAX_STEPS = 4096
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [ipu_pkg::COUNT_W-1:0]          cfg_data,
	input  wire                                 item_valid,
	output logic                                item_stall,
	input  wire ipu_pkg::item_t                 item,
	output logic                                result_valid,
	input  wire                                 result_stall,
	output ipu_pkg::result_t                    result
);

	localparam int ROWS_RAW = (MAX_STEPS + ipu_pkg::CELLS - 1) / ipu_pkg::CELLS;
	localparam int ROWS     = (ROWS_RAW < 2) ? 2 : ROWS_RAW;
	localparam int ROW_W    = $clog2(ROWS);
	localparam int EFF_W    = $clog2(MAX_STEPS + 1);
	localparam int CMP_W    = (EFF_W > ipu_pkg::FULL_STEP_W) ? EFF_W : ipu_pkg::FULL_STEP_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_SEARCH,
		ST_SETTLE,
		ST_REDUCE,
		ST_OUT
	} state_t;

	state_t                         state_q;
	logic [EFF_W-1:0]               eff_q;
	logic [ROW_W-1:0]               row_q;
	logic [ROW_W-1:0]               hi_row_q;
	logic [ipu_pkg::STEP_W-1:0]     start_q;
	logic [ipu_pkg::STEP_W-1:0]     lim_q;
	logic [ipu_pkg::SIZE_W-1:0]     size_q;
	logic                           last_q;
	logic [ipu_pkg::LANE_W-1:0]     red_q;
	logic                           result_valid_q;
	ipu_pkg::result_t               result_q;

	logic                           item_take;
	logic                           active;
	logic [ipu_pkg::STEP_W-1:0]     lim;
	logic [ipu_pkg::FULL_STEP_W-1:0] start_shift;
	logic [ipu_pkg::FULL_STEP_W-1:0] lim_shift;
	logic                           out_free;

	ipu_pkg::cell_cmd_t             cmd;
	logic [ipu_pkg::CELLS-1:0]      lane_en;
	ipu_pkg::best_t                 chain [ipu_pkg::CELLS];

	assign cfg_ready = 1'b1;

	// effective count is the register clipped to the store depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_q <= '0;
		end else if (cfg_valid) begin
			if (32'(cfg_data) > 32'(MAX_STEPS)) begin
				eff_q <= EFF_W'(MAX_STEPS);
			end else begin
				eff_q <= EFF_W'(cfg_data);
			end
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign item_take  = item_valid && !item_stall;

	// clip the span to the step count
	assign active = (item.start_step <= item.end_step)
		&& (CMP_W'(item.start_step) < CMP_W'(eff_q));
	assign lim = (CMP_W'(item.end_step) < CMP_W'(eff_q))
		? item.end_step : ipu_pkg::STEP_W'(eff_q - EFF_W'(1));
	assign start_shift = ipu_pkg::FULL_STEP_W'(item.start_step) >> ipu_pkg::LANE_W;
	assign lim_shift   = ipu_pkg::FULL_STEP_W'(lim) >> ipu_pkg::LANE_W;

	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		cmd.op   = ipu_pkg::OP_NONE;
		cmd.size = size_q;
		unique case (state_q)
			ST_CLEAR:  cmd.op = ipu_pkg::OP_CLEAR;
			ST_WALK:   cmd.op = ipu_pkg::OP_ADD;
			ST_DRAIN:  cmd.op = ipu_pkg::OP_START;
			ST_SEARCH: cmd.op = ipu_pkg::OP_SEARCH;
			ST_REDUCE: cmd.op = ipu_pkg::OP_REDUCE;
			default:   cmd.op = ipu_pkg::OP_NONE;
		endcase
	end

	always_comb begin
		logic [ipu_pkg::FULL_STEP_W-1:0] step;
		for (int l = 0; l < ipu_pkg::CELLS; l++) begin
			step = (ipu_pkg::FULL_STEP_W'(row_q) << ipu_pkg::LANE_W)
				| ipu_pkg::FULL_STEP_W'(l);
			if (state_q == ST_SEARCH) begin
				lane_en[l] = CMP_W'(step) < CMP_W'(eff_q);
			end else begin
				lane_en[l] = (step >= ipu_pkg::FULL_STEP_W'(start_q))
					&& (step <= ipu_pkg::FULL_STEP_W'(lim_q));
			end
		end
	end

	for (genvar g = 0; g < ipu_pkg::CELLS; g++) begin : g_cell
		ipu_pkg::best_t cin;
		if (g == 0) begin : g_head
			assign cin = '0;
		end else begin : g_link
			assign cin = chain[g-1];
		end
		ipu_cell #(
			.ROWS (ROWS),
			.LANE (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.row       (row_q),
			.en        (lane_en[g]),
			.chain_in  (cin),
			.chain_out (chain[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			row_q          <= '0;
			hi_row_q       <= '0;
			start_q        <= '0;
			lim_q          <= '0;
			size_q         <= '0;
			last_q         <= 1'b0;
			red_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (row_q == ROW_W'(ROWS - 1)) begin
						row_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				ST_IDLE: begin
					if (item_take) begin
						start_q  <= item.start_step;
						lim_q    <= lim;
						size_q   <= item.size_bytes;
						last_q   <= item.last_interval;
						row_q    <= start_shift[ROW_W-1:0];
						hi_row_q <= lim_shift[ROW_W-1:0];
						if (active) begin
							state_q <= ST_WALK;
						end else if (item.last_interval) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_WALK: begin
					if (row_q == hi_row_q) begin
						state_q <= last_q ? ST_DRAIN : ST_IDLE;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				ST_DRAIN: begin
					row_q   <= '0;
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (row_q == ROW_W'(ROWS - 1)) begin
						state_q <= ST_SETTLE;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				ST_SETTLE: begin
					red_q   <= '0;
					state_q <= ST_REDUCE;
				end
				ST_REDUCE: begin
					if (red_q == ipu_pkg::LANE_W'(ipu_pkg::CELLS - 1)) begin
						state_q <= ST_OUT;
					end else begin
						red_q <= red_q + ipu_pkg::LANE_W'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						result_q.peak_bytes <= chain[ipu_pkg::CELLS-1].usage;
						result_q.peak_step  <=
							chain[ipu_pkg::CELLS-1].step[ipu_pkg::STEP_W-1:0];
						result_valid_q      <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

>>> src/ipu_checker.sv
// port-level checks for the interval peak usage block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ipu_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            item_valid,
	input wire                            item_stall,
	input wire ipu_pkg::item_t            item,
	input wire                            result_valid,
	input wire                            result_stall,
	input wire ipu_pkg::result_t          result
);

	logic item_xfer;
	assign item_xfer = item_valid && !item_stall;

	// a held result keeps its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// no result appears right after an item transfer
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> !$rose(result_valid))
		else $error("result raised one cycle after an item transfer");

	// the last interval blocks further items while the peak is searched
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer && item.last_interval |=> item_stall)
		else $error("item taken right after the last interval");

	// a new result only follows a cycle in which items were held off
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result raised while items were being taken");

endmodule

bind interval_peak_usage_core ipu_checker u_ipu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
